### hdl/ofdc_pkg.sv
// Types, constants and helper functions shared by the frame decrypt and check block.
`default_nettype none

package ofdc_pkg;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 2;
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
    localparam cfg_index_t REG_CIPHER_PID = 2'd0;
    localparam cfg_index_t REG_MAX_LENGTH = 2'd1;

    // Register reset values
    localparam logic [7:0] CIPHER_PID_RESET = 8'd242;
    localparam logic [7:0] MAX_LENGTH_RESET = 8'd66;

    // Frame layout and algorithm constants
    localparam logic [7:0]  MIN_LENGTH     = 8'd10;
    localparam logic [7:0]  OFF_SEED_HIGH  = 8'd3;
    localparam logic [7:0]  OFF_SEED_LOW   = 8'd4;
    localparam logic [7:0]  OFF_BODY_START = 8'd5;
    localparam logic [7:0]  OFF_ID_DONE    = 8'd7;
    localparam logic [15:0] CRC_POLY       = 16'h1021;
    localparam logic [15:0] CIPHER_TAP     = 16'd62965;
    localparam logic [7:0]  CIPHER_MASK    = 8'd90;
    localparam int unsigned CIPHER_STEPS   = 5;

    // Result status codes
    typedef enum logic [1:0] {
        ST_PROGRESS   = 2'd0,
        ST_CRC_OK     = 2'd1,
        ST_CRC_BAD    = 2'd2,
        ST_BAD_LENGTH = 2'd3
    } status_t;

    // Five steps of the right-shifting keystream register.
    function automatic logic [15:0] cipher_advance(input logic [15:0] state);
        logic [15:0] r;
        r = state;
        for (int k = 0; k < CIPHER_STEPS; k++) begin
            if (r[0]) begin
                r = (r >> 1) ^ CIPHER_TAP;
            end else begin
                r = r >> 1;
            end
        end
        return r;
    endfunction

    // One byte of CRC-16, polynomial 0x1021, most significant bit first.
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] r;
        r = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (r[15]) begin
                r = {r[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                r = {r[14:0], 1'b0};
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### hdl/openthings_frame_decrypt_check_core.sv
// Top level: receive-side decipher and CRC check of one radio frame, one byte per request.
`default_nettype none

// This block takes a received frame one byte per request, the length byte
// flagged by s_first, and returns one result per byte: header bytes 0 to 4
// as received, body bytes deciphered with the 16-bit keystream seeded from
// cipher_pid and the frame's seed, the byte's offset, the device id once
// bytes 5 to 7 are in, and on the final byte a status of CRC good or CRC
// mismatch. A length byte outside 10..max_length gives a single result with
// status bad length and opens no frame. Bytes that arrive with no frame open
// give no result, and a new length byte inside a frame drops that frame
// silently. Throughput is one request per clock while no held result stalls
// the input: the five keystream steps and the eight CRC steps for a byte are
// unrolled into the single logic stage between the frame state and the
// result register, and the result appears in the cycle after its request is
// taken. The result register is the only thing that can hold the input back:
// s_ready is low only while a result is held and m_ready is low. Configuration
// writes are taken in any cycle (cfg_ready is always high) but are meant to be
// made only while no frame is in progress and no result is waiting.
module openthings_frame_decrypt_check_core (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    // Configuration write channel
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire ofdc_pkg::cfg_index_t    cfg_index,
    input  wire logic [7:0]              cfg_data,
    // Byte input channel
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic [7:0]              s_data_in,
    input  wire logic                    s_first,
    // Result channel
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic [7:0]                   m_data_out,
    output logic [7:0]                   m_offset,
    output logic [23:0]                  m_device_id,
    output logic                         m_last,
    output ofdc_pkg::status_t            m_status
);

    import ofdc_pkg::*;

    // Configuration registers
    logic [7:0]  cipher_pid_reg;
    logic [7:0]  max_length_reg;

    // Frame state
    logic        frame_active_reg,  frame_active_next;
    logic [7:0]  byte_offset_reg,   byte_offset_next;
    logic [7:0]  frame_length_reg,  frame_length_next;
    logic [15:0] cipher_state_reg,  cipher_state_next;
    logic [15:0] crc_reg,           crc_next;
    logic [7:0]  crc_high_reg,      crc_high_next;
    logic [23:0] device_id_reg,     device_id_next;

    // Result register
    logic        m_valid_reg,       m_valid_next;
    logic [7:0]  data_out_reg,      data_out_next;
    logic [7:0]  offset_reg,        offset_next;
    logic [23:0] id_out_reg,        id_out_next;
    logic        last_reg,          last_next;
    status_t     status_reg,        status_next;
    logic        produce;

    // Per-byte datapath
    logic        s_take;
    logic        len_ok;
    logic [7:0]  off_inc;
    logic [8:0]  off_plus1;
    logic [8:0]  off_plus2;
    logic [15:0] cipher_adv;
    logic [7:0]  plain;
    logic [23:0] id_shifted;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign s_take    = s_valid && s_ready;

    assign len_ok     = (s_data_in >= MIN_LENGTH) && (s_data_in <= max_length_reg);
    assign off_inc    = byte_offset_reg + 8'd1;
    assign off_plus1  = {1'b0, off_inc} + 9'd1;
    assign off_plus2  = {1'b0, off_inc} + 9'd2;
    assign cipher_adv = cipher_advance(cipher_state_reg);
    assign plain      = cipher_adv[7:0] ^ s_data_in ^ CIPHER_MASK;
    assign id_shifted = {device_id_reg[15:0], plain};

    always_comb begin
        frame_active_next = frame_active_reg;
        byte_offset_next  = byte_offset_reg;
        frame_length_next = frame_length_reg;
        cipher_state_next = cipher_state_reg;
        crc_next          = crc_reg;
        crc_high_next     = crc_high_reg;
        device_id_next    = device_id_reg;

        produce       = 1'b0;
        data_out_next = s_data_in;
        offset_next   = 8'd0;
        id_out_next   = 24'd0;
        last_next     = 1'b0;
        status_next   = ST_PROGRESS;

        if (s_take) begin
            if (s_first) begin
                // A length byte always yields a result; a good one opens a frame.
                produce           = 1'b1;
                frame_active_next = len_ok;
                if (len_ok) begin
                    byte_offset_next  = 8'd0;
                    frame_length_next = s_data_in;
                    cipher_state_next = 16'd0;
                    crc_next          = 16'd0;
                    crc_high_next     = 8'd0;
                    device_id_next    = 24'd0;
                end else begin
                    last_next   = 1'b1;
                    status_next = ST_BAD_LENGTH;
                end
            end else if (frame_active_reg) begin
                produce          = 1'b1;
                byte_offset_next = off_inc;
                offset_next      = off_inc;
                if (off_inc < OFF_BODY_START) begin
                    // Plain header; the seed is captured as it passes.
                    if (off_inc == OFF_SEED_HIGH) begin
                        cipher_state_next = {8'd0, s_data_in};
                    end else if (off_inc == OFF_SEED_LOW) begin
                        cipher_state_next = {cipher_pid_reg ^ cipher_state_reg[7:0],
                                             s_data_in};
                    end
                end else begin
                    cipher_state_next = cipher_adv;
                    data_out_next     = plain;
                    if (off_inc <= OFF_ID_DONE) begin
                        device_id_next = id_shifted;
                    end
                    if (off_inc >= OFF_ID_DONE) begin
                        id_out_next = device_id_next;
                    end
                    if (off_plus2 <= {1'b0, frame_length_reg}) begin
                        crc_next = crc_feed(crc_reg, plain);
                    end else if (off_plus1 == {1'b0, frame_length_reg}) begin
                        crc_high_next = plain;
                    end else begin
                        // Final byte: compare the received check value.
                        frame_active_next = 1'b0;
                        last_next         = 1'b1;
                        status_next       = ({crc_high_reg, plain} == crc_reg) ?
                                            ST_CRC_OK : ST_CRC_BAD;
                    end
                end
            end
        end

        if (produce) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cipher_pid_reg   <= CIPHER_PID_RESET;
            max_length_reg   <= MAX_LENGTH_RESET;
            frame_active_reg <= 1'b0;
            byte_offset_reg  <= 8'd0;
            frame_length_reg <= 8'd0;
            cipher_state_reg <= 16'd0;
            crc_reg          <= 16'd0;
            crc_high_reg     <= 8'd0;
            device_id_reg    <= 24'd0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_CIPHER_PID: cipher_pid_reg <= cfg_data;
                    REG_MAX_LENGTH: max_length_reg <= cfg_data;
                    default: ;
                endcase
            end
            frame_active_reg <= frame_active_next;
            byte_offset_reg  <= byte_offset_next;
            frame_length_reg <= frame_length_next;
            cipher_state_reg <= cipher_state_next;
            crc_reg          <= crc_next;
            crc_high_reg     <= crc_high_next;
            device_id_reg    <= device_id_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    // Result payload needs no reset; it is loaded only with a new result.
    always_ff @(posedge aclk) begin
        if (produce) begin
            data_out_reg <= data_out_next;
            offset_reg   <= offset_next;
            id_out_reg   <= id_out_next;
            last_reg     <= last_next;
            status_reg   <= status_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_data_out  = data_out_reg;
    assign m_offset    = offset_reg;
    assign m_device_id = id_out_reg;
    assign m_last      = last_reg;
    assign m_status    = status_reg;

endmodule

`default_nettype wire

### hdl/ofdc_checker.sv
// Port-level assertions for the frame decrypt and check block, with the bind that attaches them.
`default_nettype none

module ofdc_checker (
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_ready,
    input wire logic                 m_valid,
    input wire logic                 m_ready,
    input wire logic [7:0]           m_data_out,
    input wire logic [7:0]           m_offset,
    input wire logic [23:0]          m_device_id,
    input wire logic                 m_last,
    input wire ofdc_pkg::status_t    m_status
);

    import ofdc_pkg::*;

    // A held result must not change until it is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data_out) && $stable(m_offset)
            && $stable(m_device_id) && $stable(m_last) && $stable(m_status))
        else $error("result changed while stalled");

    // The input side is only held back by an untaken result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with no result pending");

    // Only the final result of a frame carries a verdict.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last == (m_status != ST_PROGRESS)))
        else $error("last flag and status disagree");

    // Bad length results and early bytes carry no device id.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_offset < OFF_ID_DONE || m_status == ST_BAD_LENGTH)
            |-> m_device_id == 24'd0)
        else $error("device id shown before it is complete");

    // Reset empties the result register.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind openthings_frame_decrypt_check_core ofdc_checker u_ofdc_checker (.*);

`default_nettype wire
